FILE: sv/jws_pkg.sv
`timescale 1ns / 1ps
package jws_pkg;

   localparam int MAX_LEN      = 32;
   localparam int PREFIX_LIMIT = 4;

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int NUM_W  = $clog2(6 * MAX_LEN * MAX_LEN * MAX_LEN + 1);
   localparam int PW     = $clog2(PREFIX_LIMIT + 1);
   localparam int Q_W    = 16;
   localparam int FRAC_W = 15;
   localparam int ONE_Q  = 32768;
   localparam int CNT_W  = $clog2(Q_W);
   localparam int PS_W   = PW + Q_W;
   localparam int PROD_W = PS_W + Q_W;
   localparam int BON_W  = PROD_W - FRAC_W;
   localparam int SUM_W  = BON_W + 1;

   localparam logic [15:0] PREFIX_SCALE_RESET = 16'd6554;
   localparam logic [15:0] RESULT_CAP_RESET   = 16'd32768;

   localparam logic CSR_PREFIX_SCALE = 1'b0;
   localparam logic CSR_RESULT_CAP   = 1'b1;

   typedef struct packed {
      logic       string_select;
      logic [7:0] char_code;
      logic       is_empty;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [15:0] similarity;
      logic [5:0]  match_count;
      logic        truncated;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_M_ROW, S_M_RD, S_M_CMP, S_T_ROW, S_T_SCAN, S_T_CMP,
      S_P_CHK, S_P_CMP, S_A1, S_A2, S_A3, S_DIV, S_B1, S_B2, S_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_INIT, OP_ZERO_FINISH, OP_ROW_START, OP_ROW_SKIP,
      OP_MATCH_CMP, OP_T_INIT, OP_T_SKIP_I, OP_T_SKIP_K, OP_T_CMP, OP_P_INIT,
      OP_P_CMP, OP_ARITH1, OP_ARITH2, OP_ARITH3, OP_DIV_STEP, OP_BONUS1,
      OP_BONUS2, OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic lengths_zero;
      logic i_done;
      logic row_empty;
      logic hit;
      logic j_last;
      logic m_zero;
      logic fm_i;
      logic k_done;
      logic sm_k;
      logic p_go;
      logic chars_eq;
      logic div_last;
   } status_type;

endpackage

FILE: sv/jws_ram.sv
`timescale 1ns / 1ps
module jws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/jws_ctrl.sv
`timescale 1ns / 1ps
module jws_ctrl
   import jws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  req_type    req_data,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && req_data.string_select &&
                (req_data.is_empty || req_data.last_char)) begin
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = status.lengths_zero ? S_IDLE : S_M_ROW;
         end
         S_M_ROW: begin
            if (status.i_done) begin
               state_in = status.m_zero ? S_IDLE : S_T_ROW;
            end else if (!status.row_empty) begin
               state_in = S_M_RD;
            end
         end
         S_M_RD:  state_in = S_M_CMP;
         S_M_CMP: begin
            state_in = (status.hit || status.j_last) ? S_M_ROW : S_M_RD;
         end
         S_T_ROW: begin
            if (status.i_done) begin
               state_in = S_P_CHK;
            end else if (status.fm_i) begin
               state_in = S_T_SCAN;
            end
         end
         S_T_SCAN: begin
            if (status.k_done) begin
               state_in = S_P_CHK;
            end else if (status.sm_k) begin
               state_in = S_T_CMP;
            end
         end
         S_T_CMP: state_in = S_T_ROW;
         S_P_CHK: state_in = status.p_go ? S_P_CMP : S_A1;
         S_P_CMP: state_in = status.chars_eq ? S_P_CHK : S_A1;
         S_A1:    state_in = S_A2;
         S_A2:    state_in = S_A3;
         S_A3:    state_in = S_DIV;
         S_DIV:   state_in = status.div_last ? S_B1 : S_DIV;
         S_B1:    state_in = S_B2;
         S_B2:    state_in = S_OUT;
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd.op = OP_NONE;
      busy   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op = OP_LOAD;
            end
         end
         S_START: cmd.op = status.lengths_zero ? OP_ZERO_FINISH : OP_INIT;
         S_M_ROW: begin
            if (status.i_done) begin
               cmd.op = status.m_zero ? OP_ZERO_FINISH : OP_T_INIT;
            end else if (status.row_empty) begin
               cmd.op = OP_ROW_SKIP;
            end else begin
               cmd.op = OP_ROW_START;
            end
         end
         S_M_CMP: cmd.op = OP_MATCH_CMP;
         S_T_ROW: begin
            if (status.i_done) begin
               cmd.op = OP_P_INIT;
            end else if (!status.fm_i) begin
               cmd.op = OP_T_SKIP_I;
            end
         end
         S_T_SCAN: begin
            if (status.k_done) begin
               cmd.op = OP_P_INIT;
            end else if (!status.sm_k) begin
               cmd.op = OP_T_SKIP_K;
            end
         end
         S_T_CMP: cmd.op = OP_T_CMP;
         S_P_CMP: cmd.op = OP_P_CMP;
         S_A1:    cmd.op = OP_ARITH1;
         S_A2:    cmd.op = OP_ARITH2;
         S_A3:    cmd.op = OP_ARITH3;
         S_DIV:   cmd.op = OP_DIV_STEP;
         S_B1:    cmd.op = OP_BONUS1;
         S_B2:    cmd.op = OP_BONUS2;
         S_OUT:   cmd.op = OP_FINISH;
         default: cmd.op = OP_NONE;
      endcase
   end

endmodule

FILE: sv/jws_datapath.sv
`timescale 1ns / 1ps
module jws_datapath
   import jws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output status_type  status,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_LEN);

   // control state
   logic [LEN_W-1:0]   len1_ff, len1_in, len2_ff, len2_in;
   logic               ovf_ff, ovf_in, closed_ff, closed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        scale_ff, scale_in, cap_ff, cap_in;
   // work registers
   logic [LEN_W-1:0]   i_ff, i_in, j_ff, j_in, m_ff, m_in, c_ff, c_in;
   logic [MAX_LEN-1:0] fm_ff, fm_in, sm_ff, sm_in;
   logic [PW-1:0]      p_ff, p_in;
   logic [NUM_W-1:0]   mm_ff, mm_in, ll_ff, ll_in, lsum_ff, lsum_in, mc2_ff, mc2_in;
   logic [NUM_W-1:0]   t1_ff, t1_in, t2_ff, t2_in, mll_ff, mll_in, den_ff, den_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic               nbit_ff, nbit_in;
   logic [Q_W-1:0]     q_ff, q_in, diff_ff, diff_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PS_W-1:0]    ps_ff, ps_in;
   logic [BON_W-1:0]   bonus_ff, bonus_in;
   rsp_type            rsp_ff, rsp_in;

   // combinational
   logic [LEN_W-1:0]   l1_eff, big, shorter;
   logic [LEN_W:0]     win, lo, hi, i_wide, j_wide;
   logic               we_a, we_b;
   logic [7:0]         rd_a, rd_b;
   logic [NUM_W-1:0]   num;
   logic [NUM_W:0]     rem2;
   logic [PROD_W-1:0]  prod;
   logic [SUM_W-1:0]   sum;

   jws_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first (
      .clock (clock),
      .we    (we_a),
      .waddr (l1_eff[ADDR_W-1:0]),
      .wdata (req_data.char_code),
      .raddr (i_ff[ADDR_W-1:0]),
      .rdata (rd_a)
   );

   jws_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second (
      .clock (clock),
      .we    (we_b),
      .waddr (len2_ff[ADDR_W-1:0]),
      .wdata (req_data.char_code),
      .raddr (j_ff[ADDR_W-1:0]),
      .rdata (rd_b)
   );

   // window and row bounds
   always_comb begin
      l1_eff  = closed_ff ? '0 : len1_ff;
      big     = (len1_ff > len2_ff) ? len1_ff : len2_ff;
      shorter = (len1_ff < len2_ff) ? len1_ff : len2_ff;
      win     = ((big >> 1) >= LEN_W'(1)) ? {1'b0, (big >> 1) - LEN_W'(1)} : '0;
      i_wide  = {1'b0, i_ff};
      j_wide  = {1'b0, j_ff};
      lo      = (i_wide > win) ? i_wide - win : '0;
      hi      = i_wide + win + (LEN_W+1)'(1);
      if (hi > {1'b0, len2_ff}) begin
         hi = {1'b0, len2_ff};
      end
   end

   always_comb begin
      status.lengths_zero = (len1_ff == '0) || (len2_ff == '0);
      status.i_done       = (i_ff >= len1_ff);
      status.row_empty    = (lo >= hi);
      status.chars_eq     = (rd_a == rd_b);
      status.hit          = !sm_ff[j_ff[ADDR_W-1:0]] && status.chars_eq;
      status.j_last       = (j_wide + (LEN_W+1)'(1) >= hi);
      status.m_zero       = (m_ff == '0);
      status.fm_i         = fm_ff[i_ff[ADDR_W-1:0]];
      status.k_done       = (j_ff >= len2_ff);
      status.sm_k         = sm_ff[j_ff[ADDR_W-1:0]];
      status.p_go         = (i_ff < LEN_W'(PREFIX_LIMIT)) && (i_ff < shorter);
      status.div_last     = (cnt_ff == CNT_W'(Q_W - 1));
   end

   always_comb begin
      len1_in = len1_ff;  len2_in = len2_ff;
      ovf_in = ovf_ff;    closed_in = closed_ff;
      rsp_valid_in = 1'b0;
      scale_in = scale_ff; cap_in = cap_ff;
      i_in = i_ff; j_in = j_ff; m_in = m_ff; c_in = c_ff;
      fm_in = fm_ff; sm_in = sm_ff; p_in = p_ff;
      mm_in = mm_ff; ll_in = ll_ff; lsum_in = lsum_ff; mc2_in = mc2_ff;
      t1_in = t1_ff; t2_in = t2_ff; mll_in = mll_ff; den_in = den_ff;
      rem_in = rem_ff; nbit_in = nbit_ff; q_in = q_ff; cnt_in = cnt_ff;
      ps_in = ps_ff; diff_in = diff_ff; bonus_in = bonus_ff;
      rsp_in = rsp_ff;
      we_a = 1'b0; we_b = 1'b0;
      num  = (t1_ff << 1) + t2_ff;
      rem2 = {rem_ff, (cnt_ff == '0) ? nbit_ff : 1'b0};
      prod = PROD_W'(ps_ff) * PROD_W'(diff_ff);
      sum  = SUM_W'(q_ff) + SUM_W'(bonus_ff);

      if (csr_we) begin
         case (csr_index)
            CSR_PREFIX_SCALE: scale_in = csr_wdata;
            CSR_RESULT_CAP:   cap_in   = csr_wdata;
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            if (!req_data.string_select) begin
               // a closed first string means this request opens a new pair
               if (closed_ff) begin
                  len2_in = '0;
                  ovf_in  = 1'b0;
               end
               closed_in = req_data.is_empty || req_data.last_char;
               if (req_data.is_empty) begin
                  len1_in = '0;
               end else if (l1_eff < MAXL) begin
                  we_a    = 1'b1;
                  len1_in = l1_eff + LEN_W'(1);
               end else begin
                  len1_in = l1_eff;
                  ovf_in  = 1'b1;
               end
            end else begin
               if (req_data.is_empty) begin
                  len2_in = '0;
               end else if (len2_ff < MAXL) begin
                  we_b    = 1'b1;
                  len2_in = len2_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         OP_INIT: begin
            i_in = '0; m_in = '0; c_in = '0;
            fm_in = '0; sm_in = '0;
         end
         OP_ROW_START: j_in = lo[LEN_W-1:0];
         OP_ROW_SKIP:  i_in = i_ff + LEN_W'(1);
         OP_MATCH_CMP: begin
            if (status.hit) begin
               fm_in[i_ff[ADDR_W-1:0]] = 1'b1;
               sm_in[j_ff[ADDR_W-1:0]] = 1'b1;
               m_in = m_ff + LEN_W'(1);
               i_in = i_ff + LEN_W'(1);
            end else begin
               j_in = j_ff + LEN_W'(1);
               if (status.j_last) begin
                  i_in = i_ff + LEN_W'(1);
               end
            end
         end
         OP_T_INIT, OP_P_INIT: begin
            i_in = '0; j_in = '0;
         end
         OP_T_SKIP_I: i_in = i_ff + LEN_W'(1);
         OP_T_SKIP_K: j_in = j_ff + LEN_W'(1);
         OP_T_CMP: begin
            if (!status.chars_eq) begin
               c_in = c_ff + LEN_W'(1);
            end
            i_in = i_ff + LEN_W'(1);
            j_in = j_ff + LEN_W'(1);
         end
         OP_P_CMP: begin
            if (status.chars_eq) begin
               i_in = i_ff + LEN_W'(1);
               j_in = j_ff + LEN_W'(1);
            end
         end
         OP_ARITH1: begin
            p_in    = i_ff[PW-1:0];
            mm_in   = NUM_W'(m_ff) * NUM_W'(m_ff);
            ll_in   = NUM_W'(len1_ff) * NUM_W'(len2_ff);
            lsum_in = NUM_W'(len1_ff) + NUM_W'(len2_ff);
            mc2_in  = (NUM_W'(m_ff) << 1) - NUM_W'(c_ff);
         end
         OP_ARITH2: begin
            t1_in  = mm_ff * lsum_ff;
            t2_in  = mc2_ff * ll_ff;
            mll_in = NUM_W'(m_ff) * ll_ff;
         end
         OP_ARITH3: begin
            // quotient fits Q_W bits, so the top of num<<15 seeds the remainder
            den_in  = (mll_ff << 2) + (mll_ff << 1);
            rem_in  = num >> 1;
            nbit_in = num[0];
            q_in    = '0;
            cnt_in  = '0;
         end
         OP_DIV_STEP: begin
            if (rem2 >= {1'b0, den_ff}) begin
               rem_in = NUM_W'(rem2 - {1'b0, den_ff});
               q_in   = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = NUM_W'(rem2);
               q_in   = {q_ff[Q_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_BONUS1: begin
            ps_in   = PS_W'(p_ff) * PS_W'(scale_ff);
            diff_in = Q_W'((Q_W+1)'(ONE_Q) - {1'b0, q_ff});
         end
         OP_BONUS2: bonus_in = BON_W'(prod >> FRAC_W);
         OP_FINISH: begin
            rsp_in.similarity  = (sum > SUM_W'(cap_ff)) ? cap_ff : sum[15:0];
            rsp_in.match_count = 6'(m_ff);
            rsp_in.truncated   = ovf_ff;
            rsp_valid_in = 1'b1;
            len1_in = '0; len2_in = '0; ovf_in = 1'b0; closed_in = 1'b0;
         end
         OP_ZERO_FINISH: begin
            rsp_in.similarity  = '0;
            rsp_in.match_count = '0;
            rsp_in.truncated   = ovf_ff;
            rsp_valid_in = 1'b1;
            len1_in = '0; len2_in = '0; ovf_in = 1'b0; closed_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len1_ff      <= '0;
         len2_ff      <= '0;
         ovf_ff       <= 1'b0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= PREFIX_SCALE_RESET;
         cap_ff       <= RESULT_CAP_RESET;
      end else begin
         len1_ff      <= len1_in;
         len2_ff      <= len2_in;
         ovf_ff       <= ovf_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
         scale_ff     <= scale_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;  j_ff <= j_in;  m_ff <= m_in;  c_ff <= c_in;
      fm_ff <= fm_in; sm_ff <= sm_in; p_ff <= p_in;
      mm_ff <= mm_in; ll_ff <= ll_in; lsum_ff <= lsum_in; mc2_ff <= mc2_in;
      t1_ff <= t1_in; t2_ff <= t2_in; mll_ff <= mll_in; den_ff <= den_in;
      rem_ff <= rem_in; nbit_ff <= nbit_in; q_ff <= q_in; cnt_ff <= cnt_in;
      ps_ff <= ps_in; diff_ff <= diff_in; bonus_ff <= bonus_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/jaro_winkler_similarity_core.sv
`timescale 1ns / 1ps
// Jaro-Winkler similarity engine, Q1.15 result.
// Request channel: software sends one character per request (req_data) with
// start; a request is taken on a clock edge where start is high and busy low.
// The first string (string_select 0) comes first, then the second; each ends
// with last_char or is_empty. Characters past MAX_LEN are dropped and flagged.
// Loading takes one character per cycle, back to back, busy stays low.
// The request closing the second string starts the compare and raises busy.
// Compare steps, in order: a greedy match walk over the rows, where each
// window position tried is a RAM read then a compare; the transposition
// scan; the prefix compare; the products; a divider giving one quotient bit
// per cycle; then bonus and cap. The match walk over the two character RAMs
// takes most of the time; an empty string skips the compare altogether.
// Response: rsp_valid pulses one cycle with rsp_data; there is no back
// pressure, the receiver must take it. busy falls in the same cycle.
// csr_we/csr_index/csr_wdata write prefix_scale (0) and result_cap (1); the
// user must write them only while idle, the core does not enforce it.
// Reset (synchronous) restores both registers and empties the pair; the
// character RAMs need no clearing.
module jaro_winkler_similarity_core
   import jws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer: match walk, transposition scan, prefix, arithmetic
   jws_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   // character RAMs, match flags, counters, divider and response register
   jws_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
